// ===== rtl/core/octm_pkg.sv =====
// Package for the octree occupancy mask update block.
// Holds the tree sizing constants, the item and result types and the mask helpers.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package octm_pkg;

    localparam int TREE_LEVELS = 4;
    localparam int NODE_COUNT  = ((1 << (3 * TREE_LEVELS)) - 1) / 7;
    localparam int NODE_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LVL_W       = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
    localparam int COORD_W     = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    localparam logic [7:0] FULL_MASK  = 8'hFF;
    localparam logic [7:0] EMPTY_MASK = 8'h00;

    typedef struct packed {
        logic signed [COORD_W-1:0] chunk_x;
        logic signed [COORD_W-1:0] chunk_y;
        logic signed [COORD_W-1:0] chunk_z;
        logic                      is_loaded;
        logic                      is_empty;
    } cmd_t;

    typedef struct packed {
        logic [7:0] root_loaded_mask;
        logic [7:0] root_empty_mask;
        logic       out_of_range;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } origin_t;

    typedef struct packed {
        logic [7:0] loaded;
        logic [7:0] empty;
    } mask_pair_t;

    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] waddr;
        mask_pair_t        wdata;
        logic [NODE_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [7:0] put_bit(input logic [7:0] mask, input logic [2:0] pos,
                                           input logic val);
        logic [7:0] b;
        b = 8'b1 << pos;
        return val ? (mask | b) : (mask & ~b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/octm_mask_ram.sv =====
// Mask memory: one loaded/empty mask pair per inner node of the octree.
// One write port and one registered read port; uses octm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module octm_mask_ram
    import octm_pkg::*;
(
    input  wire logic       clk,
    input  wire ram_req_t   req,
    output mask_pair_t      rdata
);

    mask_pair_t mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/octm_ctrl.sv =====
// Sequencer for the mask update: range check through one shared subtractor,
// path descent, then a read-modify-write per level going up. Uses octm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module octm_ctrl
    import octm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire cmd_t       cmd,
    input  wire origin_t    origin,
    input  wire mask_pair_t ram_rdata,
    output ram_req_t        ram_req,
    output logic            busy,
    output logic            done,
    output result_t         result
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUB,
        ST_DESC,
        ST_RD,
        ST_WR
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(TREE_LEVELS - 1);
    localparam logic [NODE_W-1:0] NODE_END = NODE_W'(NODE_COUNT - 1);

    state_t                 state_reg;
    axis_t                  axis_reg;
    cmd_t                   cmd_reg;
    logic                   oor_reg;
    logic [TREE_LEVELS-1:0] off_x_reg;
    logic [TREE_LEVELS-1:0] off_y_reg;
    logic [TREE_LEVELS-1:0] off_z_reg;
    logic [LVL_W-1:0]       lvl_reg;
    logic [NODE_W-1:0]      node_reg;
    logic [NODE_W-1:0]      path_node_reg [TREE_LEVELS];
    logic [2:0]             path_child_reg [TREE_LEVELS];
    logic [NODE_W-1:0]      clr_addr_reg;
    logic                   ld_reg;
    logic                   em_reg;
    mask_pair_t             root_reg;
    logic                   done_reg;
    result_t                result_reg;

    // Shared subtractor: coordinate minus origin, exact in 33 bits.
    logic signed [COORD_W:0]  sub_a;
    logic signed [COORD_W:0]  sub_b;
    logic signed [COORD_W:0]  diff;
    logic                     in_range;
    logic                     oor_next;

    always_comb
    begin
        unique case (axis_reg)
            AX_X:
            begin
                sub_a = {cmd_reg.chunk_x[COORD_W-1], cmd_reg.chunk_x};
                sub_b = {origin.x[COORD_W-1], origin.x};
            end
            AX_Y:
            begin
                sub_a = {cmd_reg.chunk_y[COORD_W-1], cmd_reg.chunk_y};
                sub_b = {origin.y[COORD_W-1], origin.y};
            end
            AX_Z:
            begin
                sub_a = {cmd_reg.chunk_z[COORD_W-1], cmd_reg.chunk_z};
                sub_b = {origin.z[COORD_W-1], origin.z};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        diff     = sub_a - sub_b;
        in_range = (diff[COORD_W:TREE_LEVELS] == '0);
        oor_next = oor_reg | ~in_range;
    end

    // Child index at the current level and the next node index down the path.
    logic [2:0]        child;
    logic [NODE_W+2:0] node_sum;

    always_comb
    begin
        child    = {off_y_reg[lvl_reg], off_z_reg[lvl_reg], off_x_reg[lvl_reg]};
        node_sum = {node_reg, 3'b000} + (NODE_W+3)'(child) + (NODE_W+3)'(1);
    end

    // Modified mask pair for the level being written.
    mask_pair_t new_pair;
    logic [2:0] wr_child;

    always_comb
    begin
        wr_child        = path_child_reg[lvl_reg];
        new_pair.loaded = put_bit(ram_rdata.loaded, wr_child, ld_reg);
        new_pair.empty  = put_bit(ram_rdata.empty, wr_child, em_reg);
    end

    always_comb
    begin
        ram_req.raddr = path_node_reg[lvl_reg];
        if (state_reg == ST_CLEAR)
        begin
            ram_req.wr_en = 1'b1;
            ram_req.waddr = clr_addr_reg;
            ram_req.wdata = '{loaded: EMPTY_MASK, empty: EMPTY_MASK};
        end
        else
        begin
            ram_req.wr_en = (state_reg == ST_WR);
            ram_req.waddr = path_node_reg[lvl_reg];
            ram_req.wdata = new_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            axis_reg       <= AX_X;
            cmd_reg        <= '0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            off_z_reg      <= '0;
            node_reg       <= '0;
            path_node_reg  <= '{default: '0};
            path_child_reg <= '{default: '0};
            ld_reg         <= 1'b0;
            em_reg         <= 1'b0;
            result_reg     <= '0;
            clr_addr_reg   <= '0;
            root_reg       <= '{loaded: EMPTY_MASK, empty: EMPTY_MASK};
            done_reg       <= 1'b0;
            oor_reg        <= 1'b0;
            lvl_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + NODE_W'(1);
                    if (clr_addr_reg == NODE_END)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        axis_reg  <= AX_X;
                        oor_reg   <= 1'b0;
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB:
                begin
                    oor_reg <= oor_next;
                    unique case (axis_reg)
                        AX_X:    off_x_reg <= diff[TREE_LEVELS-1:0];
                        AX_Y:    off_y_reg <= diff[TREE_LEVELS-1:0];
                        default: off_z_reg <= diff[TREE_LEVELS-1:0];
                    endcase
                    if (axis_reg == AX_Z)
                    begin
                        if (oor_next)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{root_loaded_mask: root_reg.loaded,
                                            root_empty_mask: root_reg.empty,
                                            out_of_range: 1'b1};
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            node_reg  <= '0;
                            lvl_reg   <= LVL_TOP;
                            state_reg <= ST_DESC;
                        end
                    end
                    else
                    begin
                        axis_reg <= (axis_reg == AX_X) ? AX_Y : AX_Z;
                    end
                end
                ST_DESC:
                begin
                    path_node_reg[lvl_reg]  <= node_reg;
                    path_child_reg[lvl_reg] <= child;
                    node_reg                <= node_sum[NODE_W-1:0];
                    if (lvl_reg == '0)
                    begin
                        ld_reg    <= cmd_reg.is_loaded;
                        em_reg    <= cmd_reg.is_empty;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg - LVL_W'(1);
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_WR;
                end
                ST_WR:
                begin
                    ld_reg <= (new_pair.loaded == FULL_MASK);
                    em_reg <= (new_pair.empty == FULL_MASK);
                    if (lvl_reg == LVL_TOP)
                    begin
                        // The top level of the path is the root node.
                        root_reg   <= new_pair;
                        done_reg   <= 1'b1;
                        result_reg <= '{root_loaded_mask: new_pair.loaded,
                                        root_empty_mask: new_pair.empty,
                                        out_of_range: 1'b0};
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg + LVL_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/octree_occupancy_mask_update_top.sv =====
// Octree occupancy mask update top level; uses octm_pkg, octm_ctrl and octm_mask_ram.
// An in-range item runs three subtract steps, one descent step per level and then a
// read-modify-write per level (read state, then write state) before done strobes; an
// out-of-range item strobes done after the subtract steps. Start is taken again in the
// done cycle. The receiver cannot stall results. After reset busy stays high while the
// memory is cleared; config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module octree_occupancy_mask_update_top
    import octm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire cmd_t                 cmd,
    output logic                      busy,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    origin_t    origin_reg;
    ram_req_t   ram_req;
    mask_pair_t ram_rdata;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_reg.x <= cfg_data;
                CFG_ORIGIN_Y: origin_reg.y <= cfg_data;
                CFG_ORIGIN_Z: origin_reg.z <= cfg_data;
                default:      origin_reg   <= origin_reg;
            endcase
        end
    end

    octm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .origin    (origin_reg),
        .ram_rdata (ram_rdata),
        .ram_req   (ram_req),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    octm_mask_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== verif/tb_octree_occupancy_mask_update_top.sv =====
// Self-checking testbench for the octree occupancy mask update block.
// Drives directed and random chunk updates, predicts the root masks and checks every result.
// Depends on octm_pkg and octree_occupancy_mask_update_top.
`timescale 1ns / 1ps

module tb_octree_occupancy_mask_update_top;
    import octm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 3 + 3 * TREE_LEVELS + 4;
    localparam int SPAN         = 1 << TREE_LEVELS;
    localparam int MAX_REPORTS  = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    cmd_t                 cmd       = '0;
    logic                 busy;
    logic                 done;
    result_t              result;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ORIGIN_X;
    logic [COORD_W-1:0]   cfg_data  = '0;

    typedef struct {
        cmd_t    c;
        bit      typed;
        result_t want;
    } dir_row_t;

    // Mirror of the mask memory and the origin registers.
    logic [7:0] node_loaded [NODE_COUNT];
    logic [7:0] node_empty  [NODE_COUNT];
    origin_t    tree_origin;

    result_t  root_expect_q [$];
    dir_row_t dir_rows [$];
    int       bad_count = 0;
    int       idle_run  = 0;
    int       phase_items;

    octree_occupancy_mask_update_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Applies one chunk update to the mirrored masks and returns the expected result.
    function automatic result_t update_masks(input cmd_t c);
        longint      dx;
        longint      dy;
        longint      dz;
        int unsigned walk_node [TREE_LEVELS];
        logic [2:0]  walk_child [TREE_LEVELS];
        int unsigned node;
        logic        ld;
        logic        em;
        result_t     r;
        // Differences are taken at 64 bits so that nothing wraps.
        dx = longint'($signed(c.chunk_x)) - longint'($signed(tree_origin.x));
        dy = longint'($signed(c.chunk_y)) - longint'($signed(tree_origin.y));
        dz = longint'($signed(c.chunk_z)) - longint'($signed(tree_origin.z));
        r.out_of_range = (dx < 0 || dx >= SPAN || dy < 0 || dy >= SPAN ||
                          dz < 0 || dz >= SPAN);
        if (!r.out_of_range)
        begin
            node = 0;
            for (int lvl = TREE_LEVELS; lvl >= 1; lvl--)
            begin
                walk_node[lvl-1]  = node;
                walk_child[lvl-1] = {dy[lvl-1], dz[lvl-1], dx[lvl-1]};
                node = 8 * node + walk_child[lvl-1] + 1;
            end
            ld = c.is_loaded;
            em = c.is_empty;
            for (int lvl = 0; lvl < TREE_LEVELS; lvl++)
            begin
                node = walk_node[lvl];
                node_loaded[node][walk_child[lvl]] = ld;
                node_empty[node][walk_child[lvl]]  = em;
                ld = (node_loaded[node] == FULL_MASK);
                em = (node_empty[node] == FULL_MASK);
            end
        end
        r.root_loaded_mask = node_loaded[0];
        r.root_empty_mask  = node_empty[0];
        return r;
    endfunction

    function automatic void add_row(input int x, input int y, input int z, input bit ld,
                                    input bit em, input bit typed, input logic [7:0] want_ld,
                                    input logic [7:0] want_em, input bit want_oor);
        dir_row_t row;
        row.c.chunk_x                = x;
        row.c.chunk_y                = y;
        row.c.chunk_z                = z;
        row.c.is_loaded              = ld;
        row.c.is_empty               = em;
        row.typed                    = typed;
        row.want.root_loaded_mask    = want_ld;
        row.want.root_empty_mask     = want_em;
        row.want.out_of_range        = want_oor;
        dir_rows = {dir_rows, row};
    endfunction

    // Coordinates relative to the current origin; the sum wraps at 32 bits on purpose.
    function automatic cmd_t leaf_cmd(input int rx, input int ry, input int rz,
                                      input logic ld, input logic em);
        cmd_t c;
        c.chunk_x   = tree_origin.x + rx;
        c.chunk_y   = tree_origin.y + ry;
        c.chunk_z   = tree_origin.z + rz;
        c.is_loaded = ld;
        c.is_empty  = em;
        return c;
    endfunction

    // Called at a rising edge. Returns at a rising edge with start still owned by the caller.
    task automatic issue(input cmd_t c, input int idle_pct, input bit typed,
                         input result_t typed_want);
        result_t predicted;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = update_masks(c);
        root_expect_q = {root_expect_q, (typed ? typed_want : predicted)};
        phase_items++;
        if ($urandom_range(0, 99) < 2)
        begin
            start <= 1'b0;
            while (root_expect_q.size() != 0) @(posedge clk);
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (root_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_origin(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ORIGIN_X;
        cfg_data  <= x;
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_Y;
        cfg_data  <= y;
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_Z;
        cfg_data  <= z;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tree_origin.x = x;
        tree_origin.y = y;
        tree_origin.z = z;
    endtask

    // Visits every leaf of an aligned cube of side 2^k, which fills whole subtrees.
    task automatic sweep_cube(input int k, input bit ld, input bit em, input bit noisy,
                              input int idle_pct);
        int   side;
        int   base_x;
        int   base_y;
        int   base_z;
        logic fl;
        logic fe;
        side   = 1 << k;
        base_x = $urandom_range(0, SPAN / side - 1) * side;
        base_y = $urandom_range(0, SPAN / side - 1) * side;
        base_z = $urandom_range(0, SPAN / side - 1) * side;
        for (int idx = 0; idx < (1 << (3 * k)); idx++)
        begin
            fl = ld;
            fe = em;
            if (noisy && $urandom_range(0, 99) < 5)
            begin
                fl = 1'($urandom_range(0, 1));
                fe = 1'($urandom_range(0, 1));
            end
            issue(leaf_cmd(base_x + idx % side, base_y + (idx >> (2 * k)) % side,
                           base_z + (idx >> k) % side, fl, fe), idle_pct, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int budget, input bit flood);
        int   pick;
        cmd_t c;
        phase_items = 0;
        if (flood)
            sweep_cube(TREE_LEVELS - 1, 1'b1, 1'b1, 1'b0, idle_pct);
        while (phase_items < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                c.chunk_x   = $urandom;
                c.chunk_y   = $urandom;
                c.chunk_z   = $urandom;
                c.is_loaded = 1'($urandom_range(0, 1));
                c.is_empty  = 1'($urandom_range(0, 1));
                issue(c, idle_pct, 1'b0, '0);
            end
            else if (pick < 20)
                issue(leaf_cmd(int'($urandom_range(0, SPAN + 3)) - 2,
                               int'($urandom_range(0, SPAN + 3)) - 2,
                               int'($urandom_range(0, SPAN + 3)) - 2,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                      idle_pct, 1'b0, '0);
            else if (pick < 35)
                issue(leaf_cmd($urandom_range(0, SPAN - 1), $urandom_range(0, SPAN - 1),
                               $urandom_range(0, SPAN - 1), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1))), idle_pct, 1'b0, '0);
            else
                sweep_cube(($urandom_range(0, 9) < 7) ? 1 : 2, $urandom_range(0, 99) < 85,
                           $urandom_range(0, 99) < 60, 1'b1, idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (root_expect_q.size() == 0)
            begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected result: loaded %h empty %h oor %b",
                             result.root_loaded_mask, result.root_empty_mask,
                             result.out_of_range);
            end
            else
            begin
                want = root_expect_q.pop_front();
                if (result.root_loaded_mask !== want.root_loaded_mask ||
                    result.root_empty_mask !== want.root_empty_mask ||
                    result.out_of_range !== want.out_of_range)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("mismatch: ld exp %h got %h, em exp %h got %h, oor exp %b got %b",
                                 want.root_loaded_mask, result.root_loaded_mask,
                                 want.root_empty_mask, result.root_empty_mask,
                                 want.out_of_range, result.out_of_range);
                end
            end
        end
    end

    // The count covers the memory clearing pass after reset as well.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT)
        begin
            $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        foreach (node_loaded[i])
        begin
            node_loaded[i] = '0;
            node_empty[i]  = '0;
        end
        tree_origin = '0;

        // Directed items, all with the origin at zero and the masks fresh from reset.
        add_row(0, 0, 0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
        add_row(-1, 0, 0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(0, -1, 0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(0, 0, -1, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(SPAN, 0, 0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(0, SPAN, 0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(0, 0, SPAN, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1);
        add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b1, 1'b1,
                8'h00, 8'h00, 1'b1);
        add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1, 1'b1,
                8'h00, 8'h00, 1'b1);
        add_row(SPAN - 1, SPAN - 1, SPAN - 1, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
        add_row(SPAN - 1, SPAN - 1, SPAN - 1, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0);
        add_row(0, 0, 0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0);
        // Complete the lowest 2x2x2 cube so that its parent becomes full on both masks.
        for (int idx = 1; idx < 8; idx++)
            add_row(idx & 1, (idx >> 2) & 1, (idx >> 1) & 1, 1'b1, 1'b1, 1'b0,
                    8'h00, 8'h00, 1'b0);
        add_row(1, 1, 1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(1, 1, 1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(0, 0, 0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(SPAN - 1, 0, SPAN - 1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        set_origin('0, '0, '0);
        foreach (dir_rows[i])
            issue(dir_rows[i].c, 0, dir_rows[i].typed, dir_rows[i].want);

        drain();
        set_origin(-8, 3, 1000);
        run_phase(0, 50, 1'b0);

        drain();
        set_origin(32'h80000000, 32'h7FFFFFF0, 32'h00000000);
        run_phase(53, 50, 1'b0);

        drain();
        set_origin($urandom, $urandom, $urandom);
        run_phase(20, 512, 1'b1);

        // Largest x origin: only one x column is inside, the rest wraps out of range.
        drain();
        set_origin(32'h7FFFFFFF, 32'h80000000, $urandom);
        run_phase(0, 40, 1'b0);

        drain();
        set_origin(-8, 0, -16);
        run_phase(53, 40, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_count == 0 && root_expect_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
